// ===== hw/rtl/lcd_pkg.sv =====
package lcd_pkg;

  // Request codes carried by the action field
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_COMMAND = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_INIT    = 3'd3;
  localparam logic [2:0] ACT_SETPOS  = 3'd4;
  localparam logic [2:0] ACT_CLEAR   = 3'd5;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_PULSE    = 3'd0;
  localparam logic [2:0] REG_NIB_GAP  = 3'd1;
  localparam logic [2:0] REG_POWERUP  = 3'd2;
  localparam logic [2:0] REG_INIT_GAP = 3'd3;
  localparam logic [2:0] REG_CLR_WAIT = 3'd4;

  localparam int CFG_AW = 5;

  // Register reset values
  localparam logic [7:0]  RST_PULSE    = 8'd1;
  localparam logic [15:0] RST_NIB_GAP  = 16'd100;
  localparam logic [15:0] RST_POWERUP  = 16'd50000;
  localparam logic [15:0] RST_INIT_GAP = 16'd5000;
  localparam logic [15:0] RST_CLR_WAIT = 16'd2000;

  // Controller command bytes and init nibbles
  localparam logic [3:0] INIT_NIB_8BIT = 4'h3;
  localparam logic [3:0] INIT_NIB_4BIT = 4'h2;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0c;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;

  typedef struct packed {
    logic [7:0]  pulse;
    logic [15:0] nib_gap;
    logic [15:0] powerup;
    logic [15:0] init_gap;
    logic [15:0] clr_wait;
  } lcd_cfg_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;
  } lcd_item_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       register_select;
    logic       enable;
    logic       busy_res;
    logic       rejected;
  } lcd_res_t;

endpackage

// ===== hw/rtl/lcd_in_if.sv =====
interface lcd_in_if;
  import lcd_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] byte_value;
  logic       row;
  logic [5:0] column;

  modport source(output valid, output action, output byte_value, output row,
                 output column, input ready);
  modport sink(input valid, input action, input byte_value, input row,
               input column, output ready);
endinterface

// ===== hw/rtl/lcd_out_if.sv =====
interface lcd_out_if;
  import lcd_pkg::*;

  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       register_select;
  logic       enable;
  logic       busy_res;
  logic       rejected;

  modport source(output valid, output data_nibble, output register_select,
                 output enable, output busy_res, output rejected, input ready);
  modport sink(input valid, input data_nibble, input register_select,
               input enable, input busy_res, input rejected, output ready);
endinterface

// ===== hw/rtl/lcd_cfg_regs.sv =====
module lcd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lcd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output lcd_pkg::lcd_cfg_t         cfg
);
  import lcd_pkg::*;

  lcd_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse    <= RST_PULSE;
      cfg_r.nib_gap  <= RST_NIB_GAP;
      cfg_r.powerup  <= RST_POWERUP;
      cfg_r.init_gap <= RST_INIT_GAP;
      cfg_r.clr_wait <= RST_CLR_WAIT;
    end else if (wr_en) begin
      unique case (idx)
        REG_PULSE:    cfg_r.pulse    <= pwdata[7:0];
        REG_NIB_GAP:  cfg_r.nib_gap  <= pwdata[15:0];
        REG_POWERUP:  cfg_r.powerup  <= pwdata[15:0];
        REG_INIT_GAP: cfg_r.init_gap <= pwdata[15:0];
        REG_CLR_WAIT: cfg_r.clr_wait <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_PULSE:    prdata = {24'd0, cfg_r.pulse};
      REG_NIB_GAP:  prdata = {16'd0, cfg_r.nib_gap};
      REG_POWERUP:  prdata = {16'd0, cfg_r.powerup};
      REG_INIT_GAP: prdata = {16'd0, cfg_r.init_gap};
      REG_CLR_WAIT: prdata = {16'd0, cfg_r.clr_wait};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/lcd_seq.sv =====
module lcd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  lcd_pkg::lcd_item_t item,
  input  lcd_pkg::lcd_cfg_t  cfg,
  output lcd_pkg::lcd_res_t  res
);
  import lcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWERUP,
    PH_PULSE,
    PH_GAP,
    PH_CLRWAIT
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  step;
    logic [15:0] dcnt;
    logic [7:0]  pbyte;
    logic        lnn;
    logic        clrp;
    logic        rs;
    logic        en;
    logic [3:0]  data;
  } seq_st_t;

  seq_st_t st_r;
  seq_st_t st_nxt;
  seq_st_t s;
  logic    rej;

  function automatic logic [15:0] atl1(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic seq_st_t start_pulse(seq_st_t si, logic [3:0] nib, logic [7:0] pulse);
    seq_st_t r;
    r       = si;
    r.phase = PH_PULSE;
    r.en    = 1'b1;
    r.data  = nib;
    r.dcnt  = atl1({8'd0, pulse});
    return r;
  endfunction

  function automatic seq_st_t start_byte(seq_st_t si, logic [7:0] b, logic rsv, logic clr,
                                         logic [7:0] pulse);
    seq_st_t r;
    r       = si;
    r.pbyte = b;
    r.rs    = rsv;
    r.clrp  = clr;
    r.lnn   = 1'b1;
    return start_pulse(r, b[7:4], pulse);
  endfunction

  function automatic seq_st_t start_init_step(seq_st_t si, logic [7:0] pulse);
    seq_st_t r;
    r = si;
    case (si.step)
      4'd3, 4'd4: r = start_pulse(si, INIT_NIB_8BIT, pulse);
      4'd5:       r = start_pulse(si, INIT_NIB_4BIT, pulse);
      4'd6:       r = start_byte(si, CMD_FUNC_SET, 1'b0, 1'b0, pulse);
      4'd7:       r = start_byte(si, CMD_DISP_ON, 1'b0, 1'b0, pulse);
      4'd8:       r = start_byte(si, CMD_ENTRY, 1'b0, 1'b0, pulse);
      4'd9:       r = start_byte(si, CMD_CLEAR, 1'b0, 1'b1, pulse);
      default: begin
        r.step  = 4'd0;
        r.phase = PH_IDLE;
        r.dcnt  = 16'd0;
      end
    endcase
    return r;
  endfunction

  function automatic seq_st_t unit_done(seq_st_t si, logic [7:0] pulse);
    seq_st_t r;
    r = si;
    if (si.step == 4'd0) begin
      r.phase = PH_IDLE;
      r.dcnt  = 16'd0;
    end else begin
      r.step = si.step + 4'd1;
      r      = start_init_step(r, pulse);
    end
    return r;
  endfunction

  // Advance the timer one tick, then take or reject a request
  always_comb begin
    s   = st_r;
    rej = 1'b0;

    if (s.phase != PH_IDLE) begin
      if (s.dcnt != 16'd0) s.dcnt = s.dcnt - 16'd1;
      if (s.dcnt == 16'd0) begin
        unique case (s.phase)
          PH_POWERUP: begin
            s.rs   = 1'b0;
            s.step = 4'd2;
            s      = start_pulse(s, INIT_NIB_8BIT, cfg.pulse);
          end
          PH_PULSE: begin
            s.phase = PH_GAP;
            s.en    = 1'b0;
            if (s.step >= 4'd2 && s.step <= 4'd4) s.dcnt = atl1(cfg.init_gap);
            else                                  s.dcnt = atl1(cfg.nib_gap);
          end
          PH_GAP: begin
            if (s.step >= 4'd2 && s.step <= 4'd5) begin
              s = unit_done(s, cfg.pulse);
            end else if (s.lnn) begin
              s.lnn = 1'b0;
              s     = start_pulse(s, s.pbyte[3:0], cfg.pulse);
            end else if (s.clrp) begin
              s.clrp  = 1'b0;
              s.phase = PH_CLRWAIT;
              s.dcnt  = atl1(cfg.clr_wait);
            end else begin
              s = unit_done(s, cfg.pulse);
            end
          end
          default: s = unit_done(s, cfg.pulse);
        endcase
      end
    end

    if (item.action inside {[ACT_COMMAND:ACT_CLEAR]}) begin
      if (s.phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        case (item.action)
          ACT_COMMAND: s = start_byte(s, item.byte_value, 1'b0, 1'b0, cfg.pulse);
          ACT_DATA:    s = start_byte(s, item.byte_value, 1'b1, 1'b0, cfg.pulse);
          ACT_INIT: begin
            s.step  = 4'd1;
            s.phase = PH_POWERUP;
            s.rs    = 1'b0;
            s.en    = 1'b0;
            s.data  = 4'd0;
            s.dcnt  = atl1(cfg.powerup);
          end
          ACT_SETPOS:
            s = start_byte(s, {1'b1, item.row, item.column}, 1'b0, 1'b0, cfg.pulse);
          default:     s = start_byte(s, CMD_CLEAR, 1'b0, 1'b1, cfg.pulse);
        endcase
      end
    end

    st_nxt                = fire ? s : st_r;
    res.data_nibble       = s.data;
    res.register_select   = s.rs;
    res.enable            = s.en;
    res.busy_res          = (s.phase != PH_IDLE);
    res.rejected          = rej;
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_IDLE;
      st_r.step  <= 4'd0;
      st_r.dcnt  <= 16'd0;
      st_r.pbyte <= 8'd0;
      st_r.lnn   <= 1'b0;
      st_r.clrp  <= 1'b0;
      st_r.rs    <= 1'b0;
      st_r.en    <= 1'b0;
      st_r.data  <= 4'd0;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.rejected |-> res.busy_res)
    else $error("rejected item while sequencer idle");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (st_r.dcnt == 16'd0))
    else $error("idle with running delay");

  a_en_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.en |-> (st_r.phase == PH_PULSE))
    else $error("enable high outside a pulse");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> (st_r == $past(st_r)))
    else $error("state moved without an item");

endmodule

// ===== hw/rtl/lcd_out_reg.sv =====
module lcd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  lcd_pkg::lcd_res_t res,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lcd_pkg::lcd_res_t out_res
);
  import lcd_pkg::*;

  logic     valid_r;
  lcd_res_t res_r;

  // Take a new item whenever the slot is empty or being drained
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the result of the accepted item
  always_ff @(posedge clk) begin
    if (fire) res_r <= res;
  end

  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> valid_r)
    else $error("accepted item lost its result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !fire)
    else $error("result overwritten while stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_ready && !fire) |=> !valid_r)
    else $error("result repeated after hand-off");

endmodule

// ===== hw/rtl/char_lcd_4bit_interface_sequencer_core.sv =====
// Channel   Direction  Handshake          Payload
// in_if     in         valid/ready        action, byte_value, row, column (one tick)
// out_if    out        valid/ready        data_nibble, register_select, enable,
//                                         busy_res, rejected
// cfg_*     in         APB write/read     five timing registers at 4*index
//
// Each item is one timer tick and yields one result; one item per cycle while out_if is not stalled.
// An item's work is a single pass from the sequencer state to the result
// register, so the result appears in the cycle after the item is accepted.
// A stalled result holds in the output register; a new item is taken in the
// same cycle the old one leaves. Synchronous active-low reset; no clear pass.
module char_lcd_4bit_interface_sequencer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  lcd_in_if.sink                     in_if,
  lcd_out_if.source                  out_if,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lcd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import lcd_pkg::*;

  lcd_cfg_t  cfg;
  lcd_item_t item;
  lcd_res_t  res;
  lcd_res_t  out_res;
  logic      in_rdy;
  logic      fire;

  assign item.action     = in_if.action;
  assign item.byte_value = in_if.byte_value;
  assign item.row        = in_if.row;
  assign item.column     = in_if.column;

  assign in_if.ready = in_rdy;
  assign fire        = in_if.valid && in_rdy;

  assign out_if.data_nibble     = out_res.data_nibble;
  assign out_if.register_select = out_res.register_select;
  assign out_if.enable          = out_res.enable;
  assign out_if.busy_res        = out_res.busy_res;
  assign out_if.rejected        = out_res.rejected;

  lcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lcd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  lcd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .in_ready  (in_rdy),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

endmodule
